/* hw/rtl/apd_pkg.sv */
package apd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FB_BITS     = 15;
  localparam int PROD_BITS   = 32;
  localparam int RND_BITS    = 17;
  localparam int SUM_BITS    = 18;

  localparam logic [FB_BITS-1:0] FB_RESET = 15'd14746;

  localparam int BaseDelay  [4] = '{308, 485, 750, 1014};
  localparam int RightExtra [4] = '{3, 5, 7, 11};

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          block_last;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          block_end;
  } out_t;

  // Tap delay of one stage, clamped into the line.
  function automatic int tap_delay(int stage, int right, int depth);
    int d;
    d = BaseDelay[stage % 4];
    if (right != 0) d = d + RightExtra[stage % 4];
    if (d > depth - 1) d = depth - 1;
    if (d < 1) d = 1;
    return d;
  endfunction

  // Signed sample times unsigned Q0.15 gain.
  function automatic logic signed [PROD_BITS-1:0] fb_mul(
      logic signed [SAMPLE_BITS-1:0] x, logic [FB_BITS-1:0] fb);
    logic signed [PROD_BITS-1:0] xe;
    logic signed [PROD_BITS-1:0] fe;
    xe = PROD_BITS'(x);
    fe = $signed(PROD_BITS'(fb));
    return xe * fe;
  endfunction

  // Round half up, drop 15 fraction bits.
  function automatic logic signed [RND_BITS-1:0] fb_rnd(logic signed [PROD_BITS-1:0] p);
    logic signed [PROD_BITS-1:0] s;
    s = p + 32'sd16384;
    return s[PROD_BITS-1:FB_BITS];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat(logic signed [SUM_BITS-1:0] v);
    if (v > 18'sd32767) return 16'sh7fff;
    if (v < -18'sd32768) return 16'sh8000;
    return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

/* hw/rtl/stereo_allpass_diffuser.sv */
// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+------------------------------
// input    | in        | in_valid / in_ready   | in_data  (apd_pkg::in_t)
// output   | out       | out_valid / out_ready | out_data (apd_pkg::out_t)
// config   | in        | cfg_wr_en             | cfg_wr_data (feedback gain)
//
// One transaction per cycle sustained while the output is not stalled. From the
// accepting edge to out_valid: the input register loads on that edge, then each
// stage registers the RAM read and multiply, then the subtract/saturate.
// Reset needs no clearing pass: a wrapped flag plus the write position mark
// taps never written since reset, and those read as zero.
// An output stall freezes the whole pipeline; the input register takes one more.
module stereo_allpass_diffuser #(
  parameter int LINE_DEPTH  = 1024,
  parameter int STAGE_COUNT = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [apd_pkg::FB_BITS-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  apd_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output apd_pkg::out_t                 out_data
);

  localparam int AW    = $clog2(LINE_DEPTH);
  localparam int DEPTH = 2 * STAGE_COUNT;

  logic                                   en;
  logic [apd_pkg::FB_BITS-1:0]            fb;
  logic [AW-1:0]                          pos;
  logic                                   wrapped;

  // per-frame tag, one slot per pipeline step; slot 0 is the input register
  logic                                   v_p    [DEPTH+1];
  logic                                   last_p [DEPTH+1];
  logic [AW-1:0]                          pos_p  [DEPTH];
  logic                                   wrap_p [DEPTH];

  logic signed [apd_pkg::SAMPLE_BITS-1:0] lx [STAGE_COUNT+1];
  logic signed [apd_pkg::SAMPLE_BITS-1:0] rx [STAGE_COUNT+1];

  // whole pipe advances unless a finished result is waiting
  assign en       = !v_p[DEPTH] || out_ready;
  assign in_ready = en || !v_p[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fb      <= apd_pkg::FB_RESET;
      pos     <= '0;
      wrapped <= 1'b0;
      for (int k = 0; k <= DEPTH; k++) begin
        v_p[k] <= 1'b0;
      end
    end else begin
      if (cfg_wr_en) begin
        fb <= cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        if (pos == AW'(LINE_DEPTH - 1)) begin
          pos     <= '0;
          wrapped <= 1'b1;
        end else begin
          pos <= pos + 1'b1;
        end
      end
      if (in_ready) begin
        v_p[0] <= in_valid;
      end
      if (en) begin
        for (int k = 0; k < DEPTH; k++) begin
          v_p[k+1] <= v_p[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      lx[0]     <= in_data.left_in;
      rx[0]     <= in_data.right_in;
      last_p[0] <= in_data.block_last;
      pos_p[0]  <= pos;
      wrap_p[0] <= wrapped;
    end
    if (en) begin
      for (int k = 0; k < DEPTH; k++) begin
        last_p[k+1] <= last_p[k];
      end
      for (int k = 0; k < DEPTH - 1; k++) begin
        pos_p[k+1]  <= pos_p[k];
        wrap_p[k+1] <= wrap_p[k];
      end
    end
  end

  for (genvar t = 0; t < STAGE_COUNT; t++) begin : g_stage
    apd_stage #(
      .LINE_DEPTH (LINE_DEPTH),
      .DELAY      (apd_pkg::tap_delay(t, 0, LINE_DEPTH))
    ) u_left (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .fb         (fb),
      .in_valid   (v_p[2*t]),
      .in_wrapped (wrap_p[2*t]),
      .in_pos     (pos_p[2*t]),
      .x_in       (lx[t]),
      .y_out      (lx[t+1])
    );

    apd_stage #(
      .LINE_DEPTH (LINE_DEPTH),
      .DELAY      (apd_pkg::tap_delay(t, 1, LINE_DEPTH))
    ) u_right (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .fb         (fb),
      .in_valid   (v_p[2*t]),
      .in_wrapped (wrap_p[2*t]),
      .in_pos     (pos_p[2*t]),
      .x_in       (rx[t]),
      .y_out      (rx[t+1])
    );
  end

  assign out_valid          = v_p[DEPTH];
  assign out_data.left_out  = lx[STAGE_COUNT];
  assign out_data.right_out = rx[STAGE_COUNT];
  assign out_data.block_end = last_p[DEPTH];

endmodule

/* hw/rtl/apd_stage.sv */
module apd_stage #(
  parameter int LINE_DEPTH = 1024,
  parameter int DELAY      = 308
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic [apd_pkg::FB_BITS-1:0]             fb,
  input  logic                                    in_valid,
  input  logic                                    in_wrapped,
  input  logic [$clog2(LINE_DEPTH)-1:0]           in_pos,
  input  logic signed [apd_pkg::SAMPLE_BITS-1:0]  x_in,
  output logic signed [apd_pkg::SAMPLE_BITS-1:0]  y_out
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam logic [AW:0] DLY = (AW+1)'(DELAY);
  localparam logic [AW:0] OFS = (AW+1)'(LINE_DEPTH - DELAY);

  logic signed [apd_pkg::SAMPLE_BITS-1:0] mem [LINE_DEPTH];

  logic                                   past_tap;
  logic [AW:0]                            rd_full;
  logic signed [apd_pkg::SAMPLE_BITS-1:0] rd_data;
  logic signed [apd_pkg::SAMPLE_BITS-1:0] rd_seen;
  logic signed [apd_pkg::SAMPLE_BITS-1:0] y_next;
  logic signed [apd_pkg::SAMPLE_BITS-1:0] wr_sample;

  logic                                   v1, v2, v3;
  logic                                   ok1;
  logic [AW-1:0]                          w1, w2, w3;
  logic signed [apd_pkg::SAMPLE_BITS-1:0] x1, x2, x3;
  logic signed [apd_pkg::PROD_BITS-1:0]   p1, p3;

  assign past_tap = ({1'b0, in_pos} >= DLY);
  assign rd_full  = past_tap ? ({1'b0, in_pos} - DLY) : ({1'b0, in_pos} + OFS);

  // entries older than reset read as zero
  assign rd_seen = ok1 ? rd_data : '0;
  assign y_next  = apd_pkg::sat(apd_pkg::SUM_BITS'(rd_seen)
                                - apd_pkg::SUM_BITS'(apd_pkg::fb_rnd(p1)));
  assign wr_sample = apd_pkg::sat(apd_pkg::SUM_BITS'(x3)
                                  + apd_pkg::SUM_BITS'(apd_pkg::fb_rnd(p3)));

  always_ff @(posedge clk) begin
    if (en) begin
      rd_data <= mem[rd_full[AW-1:0]];
      if (v3) begin
        mem[w3] <= wr_sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok1   <= in_wrapped || past_tap;
      p1    <= apd_pkg::fb_mul(x_in, fb);
      x1    <= x_in;
      w1    <= in_pos;
      y_out <= y_next;
      x2    <= x1;
      w2    <= w1;
      p3    <= apd_pkg::fb_mul(y_out, fb);
      x3    <= x2;
      w3    <= w2;
    end
  end

endmodule

/* verif/stereo_allpass_diffuser_tb.sv */
`timescale 1ns / 100ps

module stereo_allpass_diffuser_tb;

  // Line geometry and tap layout of the diffuser as built (default parameters).
  localparam int LINE_LEN  = 1024;
  localparam int STAGES    = 4;
  localparam int TAP_LEFT [4]        = '{308, 485, 750, 1014};
  localparam int TAP_RIGHT_EXTRA [4] = '{3, 5, 7, 11};

  // Feedback gain corners: nominal band edges, half scale and the raw 15-bit extremes.
  localparam logic [apd_pkg::FB_BITS-1:0] GAIN_BAND_LO = 15'd11469;
  localparam logic [apd_pkg::FB_BITS-1:0] GAIN_BAND_HI = 15'd18022;
  localparam logic [apd_pkg::FB_BITS-1:0] GAIN_HALF    = 15'd16384;
  localparam logic [apd_pkg::FB_BITS-1:0] GAIN_ZERO    = 15'd0;
  localparam logic [apd_pkg::FB_BITS-1:0] GAIN_FULL    = 15'h7fff;

  localparam int IDLE_PCT      = 36;
  localparam int HOLD_CYCLES   = 200;   // long receiver hold-off
  localparam int DRAIN_CYCLES  = 20;    // pipeline is 2*STAGES+1 deep
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_FRAMES  = 330;
  localparam int HOLD_FRAMES   = 150;

  localparam logic signed [15:0] S_MAX = 16'sh7fff;
  localparam logic signed [15:0] S_MIN = 16'sh8000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                        cfg_wr_en   = 1'b0;
  logic [apd_pkg::FB_BITS-1:0] cfg_wr_data = '0;
  logic                        in_valid    = 1'b0;
  logic                        in_ready;
  apd_pkg::in_t                in_data     = '0;
  logic                        out_valid;
  logic                        out_ready   = 1'b0;
  apd_pkg::out_t               out_data;

  stereo_allpass_diffuser dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Diffuser model: own copy of every delay line, the shared write pointer
  // and the feedback gain. Lines and pointer update once per accepted input transaction.
  // ---------------------------------------------------------------------------
  logic signed [15:0]          left_line  [STAGES][LINE_LEN];
  logic signed [15:0]          right_line [STAGES][LINE_LEN];
  logic [9:0]                  line_wr_pos;
  logic [apd_pkg::FB_BITS-1:0] model_gain;

  apd_pkg::out_t pending_diffused [$];   // predicted output transactions, oldest first
  int            mismatch_count = 0;

  // Stimulus shaping, owned by the test sequence (NBA writes only).
  logic idling_on = 1'b1;   // both sides insert random idle cycles
  int   hold_req  = 0;      // bumped to ask the receiver for a long hold-off

  // Q0.15 gain product, round half up: floor((x*g + 2^14) / 2^15).
  function automatic int gain_scaled(int x);
    longint p;
    p = longint'(x) * longint'(model_gain) + 64'sd16384;
    return int'(p >>> 15);
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return S_MAX;
    if (v < -32768) return S_MIN;
    return 16'(v);
  endfunction

  // One Schroeder section: y = d - g*x, line <= x + g*y.
  function automatic logic signed [15:0] allpass_section(bit right, int stage,
                                                         logic signed [15:0] x);
    int                 lag;
    logic [9:0]         rd_pos;
    logic signed [15:0] tap;
    logic signed [15:0] y;
    lag = TAP_LEFT[stage % 4];
    if (right) lag = lag + TAP_RIGHT_EXTRA[stage % 4];
    if (lag > LINE_LEN - 1) lag = LINE_LEN - 1;   // right tap of the last stage
    rd_pos = line_wr_pos - 10'(lag);
    tap = right ? right_line[stage][rd_pos] : left_line[stage][rd_pos];
    y = clip16(longint'(tap) - gain_scaled(x));
    if (right) right_line[stage][line_wr_pos] = clip16(longint'(x) + gain_scaled(y));
    else       left_line[stage][line_wr_pos]  = clip16(longint'(x) + gain_scaled(y));
    return y;
  endfunction

  function automatic apd_pkg::out_t diffuse_frame(apd_pkg::in_t f);
    logic signed [15:0] l;
    logic signed [15:0] r;
    apd_pkg::out_t      o;
    l = f.left_in;
    r = f.right_in;
    for (int s = 0; s < STAGES; s++) begin
      l = allpass_section(1'b0, s, l);
      r = allpass_section(1'b1, s, r);
    end
    line_wr_pos = line_wr_pos + 10'd1;
    o.left_out  = l;
    o.right_out = r;
    o.block_end = f.block_last;
    return o;
  endfunction

  // Mostly full-scale noise, with some rail values and some quiet signal so
  // the sections are not pinned in saturation all the time.
  function automatic logic signed [15:0] random_sample();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return S_MAX;
          1: return S_MIN;
          2: return 16'sd0;
          default: return -16'sd1;
        endcase
      end
      1, 2: return 16'($urandom_range(2047)) - 16'sd1024;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic apd_pkg::in_t random_frame();
    apd_pkg::in_t f;
    f.left_in    = random_sample();
    f.right_in   = random_sample();
    f.block_last = ($urandom_range(15) == 0);
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: optional idle cycles, then hold valid until the transaction is
  // taken. Valid is left high on return; the next call or wait_idle lowers it
  // in the same step, so a stale frame is never offered twice.
  // ---------------------------------------------------------------------------
  task automatic send_frame(input apd_pkg::in_t f);
    while (idling_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    do @(posedge clk); while (!in_ready);
    pending_diffused.push_back(diffuse_frame(f));
  endtask

  task automatic send_values(input logic signed [15:0] l, input logic signed [15:0] r,
                             input logic last);
    apd_pkg::in_t f;
    f.left_in    = l;
    f.right_in   = r;
    f.block_last = last;
    send_frame(f);
  endtask

  // Every transaction yields a result, so an empty queue means the pipe is empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_diffused.size() != 0) @(posedge clk);
  endtask

  task automatic write_gain(input logic [apd_pkg::FB_BITS-1:0] g);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= g;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    model_gain = g;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker: random ready, plus a long hold-off on request.
  // ---------------------------------------------------------------------------
  int            hold_seen = 0;
  int            hold_left = 0;
  apd_pkg::out_t want_frame;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_diffused.size() == 0) begin
          $error("unexpected transaction: left_out %0d right_out %0d block_end %0b",
                 out_data.left_out, out_data.right_out, out_data.block_end);
          mismatch_count++;
        end else begin
          want_frame = pending_diffused.pop_front();
          if (out_data.left_out !== want_frame.left_out) begin
            $error("left_out: expected %0d, got %0d", want_frame.left_out, out_data.left_out);
            mismatch_count++;
          end
          if (out_data.right_out !== want_frame.right_out) begin
            $error("right_out: expected %0d, got %0d",
                   want_frame.right_out, out_data.right_out);
            mismatch_count++;
          end
          if (out_data.block_end !== want_frame.block_end) begin
            $error("block_end: expected %0b, got %0b",
                   want_frame.block_end, out_data.block_end);
            mismatch_count++;
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !idling_on || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog.
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Rails, zero and block_last at the reset gain; also confirms the reset value.
  task automatic test_rails_at_reset_gain();
    send_values(S_MAX, S_MAX, 1'b1);
    send_values(S_MIN, S_MIN, 1'b0);
    send_values(16'sd0, 16'sd0, 1'b0);
    send_values(-16'sd1, 16'sd1, 1'b1);
    send_values(S_MAX, S_MIN, 1'b0);
    send_values(S_MIN, S_MAX, 1'b1);
    send_values(16'sd1, -16'sd1, 1'b0);
    send_values(16'sd0, 16'sd0, 1'b1);
  endtask

  // Gain 0.5 times odd samples lands exactly on a half LSB: must round up.
  task automatic test_rounding_ties();
    write_gain(GAIN_HALF);
    send_values(16'sd1, -16'sd1, 1'b0);
    send_values(16'sd3, -16'sd3, 1'b0);
    send_values(16'sd32767, -16'sd32767, 1'b1);
    send_values(-16'sd5, 16'sd5, 1'b0);
  endtask

  // Out-of-band gains are used as written: zero (pure delay) and full scale,
  // where repeated rail input drives the sections into saturation.
  task automatic test_gain_extremes();
    write_gain(GAIN_ZERO);
    send_values(S_MAX, S_MIN, 1'b0);
    send_values(16'sd1234, -16'sd4321, 1'b1);
    send_values(S_MIN, S_MAX, 1'b0);
    write_gain(GAIN_FULL);
    repeat (3) send_values(S_MAX, S_MIN, 1'b0);
    send_values(S_MIN, S_MAX, 1'b1);
    send_values(16'sd0, 16'sd0, 1'b0);
  endtask

  // Random streams over several gains; one phase runs with no idling on
  // either side. Together the phases are long enough to wrap the lines and hit all taps.
  task automatic test_random_gains();
    logic [apd_pkg::FB_BITS-1:0] gains [5];
    gains[0] = GAIN_BAND_LO;
    gains[1] = GAIN_BAND_HI;
    gains[2] = apd_pkg::FB_RESET;
    gains[3] = 15'($urandom_range(int'(GAIN_BAND_HI), int'(GAIN_BAND_LO)));
    gains[4] = 15'($urandom);
    foreach (gains[i]) begin
      write_gain(gains[i]);
      idling_on <= (i != 2);
      repeat (PHASE_FRAMES) send_frame(random_frame());
    end
    wait_idle();
    idling_on <= 1'b1;
  endtask

  // Receiver stops for a long stretch while frames keep coming: the pipe
  // fills and in_ready must drop without losing or duplicating anything.
  task automatic test_output_hold();
    write_gain(15'($urandom_range(int'(GAIN_BAND_HI), int'(GAIN_BAND_LO))));
    hold_req <= hold_req + 1;
    repeat (HOLD_FRAMES) send_frame(random_frame());
    hold_req <= hold_req + 1;
    repeat (HOLD_FRAMES) send_frame(random_frame());
  endtask

  initial begin
    for (int s = 0; s < STAGES; s++) begin
      for (int i = 0; i < LINE_LEN; i++) begin
        left_line[s][i]  = '0;
        right_line[s][i] = '0;
      end
    end
    line_wr_pos = '0;
    model_gain  = apd_pkg::FB_RESET;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_rails_at_reset_gain();
    test_rounding_ties();
    test_gain_extremes();
    test_random_gains();
    test_output_hold();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* stereo_allpass_diffuser.f */
hw/rtl/apd_pkg.sv
hw/rtl/apd_stage.sv
hw/rtl/stereo_allpass_diffuser.sv
verif/stereo_allpass_diffuser_tb.sv
